// ===== sv/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

   // Quaternion component; also names the component that takes the half root.
   typedef enum logic [1:0] {
      COMP_W = 2'd0,
      COMP_X = 2'd1,
      COMP_Y = 2'd2,
      COMP_Z = 2'd3
   } comp_type;

   localparam int NUM_COMP = 4;

endpackage

// ===== sv/rmq_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage, with sideband.
module rmq_sqrt #(
   parameter int RW     = 17,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   in_arg,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int REM_W = RW + 2;
   localparam int XW    = 2 * RW;

   logic              vld_ff  [RW];
   logic [REM_W-1:0]  rem_ff  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [XW-1:0]     x_ff    [RW];
   logic [SIDE_W-1:0] side_ff [RW];

   for (genvar t = 0; t < RW; t++) begin : g_stage
      logic              prev_vld;
      logic [REM_W-1:0]  prev_rem;
      logic [RW-1:0]     prev_root;
      logic [XW-1:0]     prev_x;
      logic [SIDE_W-1:0] prev_side;
      logic [REM_W-1:0]  cur;
      logic [REM_W-1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [RW-1:0]     root_in;

      if (t == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_x    = in_arg;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_vld  = vld_ff[t-1];
         assign prev_rem  = rem_ff[t-1];
         assign prev_root = root_ff[t-1];
         assign prev_x    = x_ff[t-1];
         assign prev_side = side_ff[t-1];
      end

      // bring down the next two radicand bits, try (4r+1)
      assign cur     = {prev_rem[REM_W-3:0], prev_x[XW-1 -: 2]};
      assign trial   = {prev_root, 2'b01};
      assign ge      = (cur >= trial);
      assign rem_in  = ge ? (cur - trial) : cur;
      assign root_in = {prev_root[RW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[t] <= 1'b0;
         end else begin
            vld_ff[t] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[t]  <= rem_in;
         root_ff[t] <= root_in;
         x_ff[t]    <= {prev_x[XW-3:0], 2'b00};
         side_ff[t] <= prev_side;
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

// ===== sv/rmq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rmq_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 18,
   parameter int Q_W    = 16,
   parameter int SIDE_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);

   localparam int HI_W = NUM_W - Q_W;
   localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

   // entry: quotient of 2^Q_W or more is flagged, rest divides bit by bit
   logic [CW-1:0]     hi_ext;
   logic [CW-1:0]     den_ext;

   logic              e_vld_ff;
   logic [DEN_W-1:0]  e_rem_ff;
   logic [Q_W-1:0]    e_lo_ff;
   logic [DEN_W-1:0]  e_den_ff;
   logic              e_ovf_ff;
   logic [SIDE_W-1:0] e_side_ff;

   assign hi_ext  = CW'(in_num[NUM_W-1:Q_W]);
   assign den_ext = CW'(in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      e_rem_ff  <= hi_ext[DEN_W-1:0];
      e_lo_ff   <= in_num[Q_W-1:0];
      e_den_ff  <= in_den;
      e_ovf_ff  <= (hi_ext >= den_ext);
      e_side_ff <= in_side;
   end

   logic              vld_ff  [Q_W];
   logic [DEN_W-1:0]  rem_ff  [Q_W];
   logic [Q_W-1:0]    lo_ff   [Q_W];
   logic [Q_W-1:0]    q_ff    [Q_W];
   logic [DEN_W-1:0]  den_ff  [Q_W];
   logic              ovf_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic              prev_vld;
      logic [DEN_W-1:0]  prev_rem;
      logic [Q_W-1:0]    prev_lo;
      logic [Q_W-1:0]    prev_q;
      logic [DEN_W-1:0]  prev_den;
      logic              prev_ovf;
      logic [SIDE_W-1:0] prev_side;
      logic [DEN_W:0]    cur;
      logic [DEN_W:0]    diff;
      logic              ge;

      if (s == 0) begin : g_first
         assign prev_vld  = e_vld_ff;
         assign prev_rem  = e_rem_ff;
         assign prev_lo   = e_lo_ff;
         assign prev_q    = '0;
         assign prev_den  = e_den_ff;
         assign prev_ovf  = e_ovf_ff;
         assign prev_side = e_side_ff;
      end else begin : g_next
         assign prev_vld  = vld_ff[s-1];
         assign prev_rem  = rem_ff[s-1];
         assign prev_lo   = lo_ff[s-1];
         assign prev_q    = q_ff[s-1];
         assign prev_den  = den_ff[s-1];
         assign prev_ovf  = ovf_ff[s-1];
         assign prev_side = side_ff[s-1];
      end

      assign cur  = {prev_rem, prev_lo[Q_W-1]};
      assign ge   = (cur >= {1'b0, prev_den});
      assign diff = cur - {1'b0, prev_den};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
         lo_ff[s]   <= {prev_lo[Q_W-2:0], 1'b0};
         q_ff[s]    <= {prev_q[Q_W-2:0], ge};
         den_ff[s]  <= prev_den;
         ovf_ff[s]  <= prev_ovf;
         side_ff[s] <= prev_side;
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quot  = q_ff[Q_W-1];
   assign out_ovf   = ovf_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion converter (Shoemake), fully pipelined.
// Stages: trace and path choice, root argument, RW-bit square root, where RW is the
//   root width, ceil((max(DATA_WIDTH,FRAC_BITS) + 3 + FRAC_BITS) / 2); 17 at defaults;
//   then the divider entry stage, the bit-per-stage dividers and the output register.
// Throughput: one word per cycle; busy is always low, rsp_valid strobes once per word.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_m00,
   input  logic signed [DATA_WIDTH-1:0] req_m01,
   input  logic signed [DATA_WIDTH-1:0] req_m02,
   input  logic signed [DATA_WIDTH-1:0] req_m10,
   input  logic signed [DATA_WIDTH-1:0] req_m11,
   input  logic signed [DATA_WIDTH-1:0] req_m12,
   input  logic signed [DATA_WIDTH-1:0] req_m20,
   input  logic signed [DATA_WIDTH-1:0] req_m21,
   input  logic signed [DATA_WIDTH-1:0] req_m22,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_w,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_z
);

   localparam int W      = DATA_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int MW     = (W > F) ? W : F;
   localparam int AW     = MW + 4;               // signed root argument
   localparam int UW     = AW - 1;               // clamped, unsigned
   localparam int XW     = UW + F;               // radicand = arg << F
   localparam int RW     = (XW + 1) / 2;         // root width
   localparam int SQ_W   = 2 * RW;
   localparam int DW     = W + 1;                // numerator, signed
   localparam int NW     = ((DW + F > RW) ? DW + F : RW) + 1;
   localparam int DEN_W  = RW + 1;               // 2*S
   localparam int HW     = RW - 1;               // S >> 1
   localparam int CMPW   = (HW > W) ? HW : W;
   localparam int SIDE_S = 2 + NUM_COMP * DW;
   localparam int SIDE_D = HW + 4;
   localparam int LAT    = RW + W + 4;

   localparam logic signed [AW-1:0] ONE_A = {{(AW-1){1'b0}}, 1'b1} << F;
   localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

   logic accept;

   // no backpressure anywhere: a word can enter every cycle
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   //---------------------------------------------------------------------------
   // Stage 1: trace and path choice
   //---------------------------------------------------------------------------
   logic signed [W+1:0] trace;
   comp_type            sel;

   assign trace = (W+2)'(req_m00) + (W+2)'(req_m11) + (W+2)'(req_m22);

   // lowest index wins ties on the diagonal
   always_comb begin
      priority if (trace > 0) begin
         sel = COMP_W;
      end else if (req_m11 > req_m00) begin
         sel = (req_m22 > req_m11) ? COMP_Z : COMP_Y;
      end else begin
         sel = (req_m22 > req_m00) ? COMP_Z : COMP_X;
      end
   end

   logic                s1_vld_ff;
   logic signed [W-1:0] s1_m_ff [9];
   comp_type            s1_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_m_ff[0] <= req_m00;
      s1_m_ff[1] <= req_m01;
      s1_m_ff[2] <= req_m02;
      s1_m_ff[3] <= req_m10;
      s1_m_ff[4] <= req_m11;
      s1_m_ff[5] <= req_m12;
      s1_m_ff[6] <= req_m20;
      s1_m_ff[7] <= req_m21;
      s1_m_ff[8] <= req_m22;
      s1_sel_ff  <= sel;
   end

   //---------------------------------------------------------------------------
   // Stage 2: root argument and the numerators of the three quotients
   //---------------------------------------------------------------------------
   logic signed [AW-1:0] arg;
   logic [UW-1:0]        arg_u;
   logic signed [DW-1:0] d_a, d_b, d_c, s_xy, s_xz, s_yz;
   logic signed [DW-1:0] num [NUM_COMP];

   assign d_a  = DW'(s1_m_ff[7]) - DW'(s1_m_ff[5]);   // m21 - m12
   assign d_b  = DW'(s1_m_ff[2]) - DW'(s1_m_ff[6]);   // m02 - m20
   assign d_c  = DW'(s1_m_ff[3]) - DW'(s1_m_ff[1]);   // m10 - m01
   assign s_xy = DW'(s1_m_ff[1]) + DW'(s1_m_ff[3]);
   assign s_xz = DW'(s1_m_ff[2]) + DW'(s1_m_ff[6]);
   assign s_yz = DW'(s1_m_ff[5]) + DW'(s1_m_ff[7]);

   always_comb begin
      unique case (s1_sel_ff)
         COMP_W: begin
            arg = AW'(s1_m_ff[0]) + AW'(s1_m_ff[4]) + AW'(s1_m_ff[8]) + ONE_A;
            num[COMP_W] = '0;   num[COMP_X] = d_a;
            num[COMP_Y] = d_b;  num[COMP_Z] = d_c;
         end
         COMP_X: begin
            arg = AW'(s1_m_ff[0]) - AW'(s1_m_ff[4]) - AW'(s1_m_ff[8]) + ONE_A;
            num[COMP_W] = d_a;  num[COMP_X] = '0;
            num[COMP_Y] = s_xy; num[COMP_Z] = s_xz;
         end
         COMP_Y: begin
            arg = AW'(s1_m_ff[4]) - AW'(s1_m_ff[8]) - AW'(s1_m_ff[0]) + ONE_A;
            num[COMP_W] = d_b;  num[COMP_X] = s_xy;
            num[COMP_Y] = '0;   num[COMP_Z] = s_yz;
         end
         COMP_Z: begin
            arg = AW'(s1_m_ff[8]) - AW'(s1_m_ff[0]) - AW'(s1_m_ff[4]) + ONE_A;
            num[COMP_W] = d_c;  num[COMP_X] = s_xz;
            num[COMP_Y] = s_yz; num[COMP_Z] = '0;
         end
         default: begin
            arg = '0;
            num[COMP_W] = '0;   num[COMP_X] = '0;
            num[COMP_Y] = '0;   num[COMP_Z] = '0;
         end
      endcase
   end

   // a negative argument only comes from a non-rotation matrix: clamp to zero
   assign arg_u = arg[AW-1] ? '0 : arg[UW-1:0];

   logic              s2_vld_ff;
   logic [SQ_W-1:0]   s2_x_ff;
   logic [SIDE_S-1:0] s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_x_ff    <= SQ_W'({arg_u, {F{1'b0}}});
      s2_side_ff <= {s1_sel_ff, num[COMP_Z], num[COMP_Y], num[COMP_X], num[COMP_W]};
   end

   //---------------------------------------------------------------------------
   // Square root, RW stages
   //---------------------------------------------------------------------------
   logic              sq_vld;
   logic [RW-1:0]     sq_root;
   logic [SIDE_S-1:0] sq_side;
   comp_type          sq_sel;
   logic              sq_zero;

   rmq_sqrt #(
      .RW     (RW),
      .SIDE_W (SIDE_S)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_vld_ff),
      .in_arg    (s2_x_ff),
      .in_side   (s2_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign sq_sel  = comp_type'(sq_side[SIDE_S-1 -: 2]);
   assign sq_zero = (sq_root == '0);

   //---------------------------------------------------------------------------
   // Four dividers: |D| * ONE + S over 2*S, one entry stage plus W stages
   //---------------------------------------------------------------------------
   logic              dv_vld  [NUM_COMP];
   logic [W-1:0]      dv_q    [NUM_COMP];
   logic              dv_ovf  [NUM_COMP];
   logic [SIDE_D-1:0] dv_side [NUM_COMP];
   comp_type          dv_sel;
   logic              dv_zero;
   logic [HW-1:0]     dv_half;
   logic [W-1:0]      half_sat;
   logic [W-1:0]      quat_in [NUM_COMP];

   assign dv_half = dv_side[0][HW-1:0];
   assign dv_sel  = comp_type'(dv_side[0][HW+1:HW]);
   assign dv_zero = dv_side[0][HW+2];

   // half root is never negative; only an oversized root saturates
   assign half_sat = (CMPW'(dv_half) > CMPW'(MAX_POS)) ? MAX_POS : W'(CMPW'(dv_half));

   for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
      logic signed [DW-1:0] lane_num;
      logic                 lane_sign;
      logic [DW-1:0]        lane_mag;
      logic [NW-1:0]        lane_n;
      logic                 q_sign;
      logic [W-1:0]         q_sat;

      assign lane_num  = sq_side[c*DW +: DW];
      assign lane_sign = lane_num[DW-1];
      assign lane_mag  = lane_sign ? DW'(-lane_num) : DW'(lane_num);
      // adding S before dividing by 2S rounds half away from zero
      assign lane_n    = NW'({lane_mag, {F{1'b0}}}) + NW'(sq_root);

      rmq_div #(
         .NUM_W  (NW),
         .DEN_W  (DEN_W),
         .Q_W    (W),
         .SIDE_W (SIDE_D)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_vld),
         .in_num    (lane_n),
         .in_den    ({sq_root, 1'b0}),
         .in_side   ({lane_sign, sq_zero, sq_sel, sq_root[RW-1:1]}),
         .out_valid (dv_vld[c]),
         .out_quot  (dv_q[c]),
         .out_ovf   (dv_ovf[c]),
         .out_side  (dv_side[c])
      );

      assign q_sign = dv_side[c][HW+3];

      always_comb begin
         if (q_sign) begin
            q_sat = (dv_ovf[c] || dv_q[c] > MIN_NEG) ? MIN_NEG : W'(-dv_q[c]);
         end else begin
            q_sat = (dv_ovf[c] || dv_q[c] > MAX_POS) ? MAX_POS : dv_q[c];
         end
      end

      // zero root: the quotient is ignored and the component is zero
      always_comb begin
         priority if (dv_sel == comp_type'(c)) begin
            quat_in[c] = half_sat;
         end else if (dv_zero) begin
            quat_in[c] = '0;
         end else begin
            quat_in[c] = q_sat;
         end
      end
   end

   //---------------------------------------------------------------------------
   // Output register
   //---------------------------------------------------------------------------
   logic         rsp_vld_ff;
   logic [W-1:0] quat_ff [NUM_COMP];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= dv_vld[0];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_COMP; c++) begin
         quat_ff[c] <= quat_in[c];
      end
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_quat_w = quat_ff[COMP_W];
   assign rsp_quat_x = quat_ff[COMP_X];
   assign rsp_quat_y = quat_ff[COMP_Y];
   assign rsp_quat_z = quat_ff[COMP_Z];

   //---------------------------------------------------------------------------
   // Assertions
   //---------------------------------------------------------------------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("accepted word did not come out after the pipeline latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result strobe without a matching accepted word");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dv_vld[0] == dv_vld[1] && dv_vld[0] == dv_vld[2] && dv_vld[0] == dv_vld[3])
      else $error("divider lanes out of step");

   a_trace_w_pos: assert property (@(posedge clock) disable iff (reset)
      (dv_vld[0] && dv_sel == COMP_W) |=> !rsp_quat_w[W-1])
      else $error("trace path gave a negative scalar part");

endmodule

// ===== tb/testbench.sv =====
// Testbench for the rotation matrix to quaternion converter: random and directed matrices.
`timescale 1ns / 100ps

module testbench;
   import rmq_pkg::*;

   localparam int DW = 16;
   localparam int FB = 14;
   localparam int LATENCY = 17 + DW + 4;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef logic signed [DW-1:0] elem_type;

   typedef struct {
      elem_type m[3][3];
   } matrix_type;

   typedef struct {
      elem_type comp[NUM_COMP];
   } quat_type;

   int error_count = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   // Saturate a wide result to the output range.
   function automatic elem_type clamp_out(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return elem_type'(v);
   endfunction

   // floor(sqrt(arg * ONE)), zero for a non-positive argument
   function automatic longint root_of(input longint arg);
      longint x;
      longint r;
      longint b;
      if (arg <= 0) return 0;
      x = arg <<< FB;
      r = 0;
      b = longint'(1) <<< 62;
      while (b > x) b = b >>> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // d / (2s), rounded half away from zero; zero root gives zero
   function automatic longint half_quot(input longint d, input longint s);
      longint mag;
      longint q;
      if (s <= 0) return 0;
      mag = (d < 0) ? -d : d;
      q = ((mag <<< FB) + s) / (2 * s);
      return (d < 0) ? -q : q;
   endfunction

   // Shoemake conversion in the block's fixed point
   function automatic quat_type convert_matrix(input matrix_type mat);
      longint a[3][3];
      longint tr;
      longint s;
      longint w;
      longint v[3];
      int i;
      int j;
      int k;
      quat_type q;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            a[r][c] = mat.m[r][c];
      tr = a[0][0] + a[1][1] + a[2][2];
      if (tr > 0) begin
         s = root_of(tr + (longint'(1) <<< FB));
         w = s >>> 1;
         v[0] = half_quot(a[2][1] - a[1][2], s);
         v[1] = half_quot(a[0][2] - a[2][0], s);
         v[2] = half_quot(a[1][0] - a[0][1], s);
      end else begin
         i = 0;
         if (a[1][1] > a[0][0]) i = 1;
         if (a[2][2] > a[i][i]) i = 2;   // strict: lowest index wins ties
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         s = root_of(a[i][i] - (a[j][j] + a[k][k]) + (longint'(1) <<< FB));
         v[i] = s >>> 1;
         w = half_quot(a[k][j] - a[j][k], s);
         v[j] = half_quot(a[j][i] + a[i][j], s);
         v[k] = half_quot(a[k][i] + a[i][k], s);
      end
      q.comp[COMP_W] = clamp_out(w);
      q.comp[COMP_X] = clamp_out(v[0]);
      q.comp[COMP_Y] = clamp_out(v[1]);
      q.comp[COMP_Z] = clamp_out(v[2]);
      return q;
   endfunction

   class quat_scoreboard;
      quat_type pending_quats[$];

      function void note_matrix(input matrix_type mat);
         pending_quats.push_back(convert_matrix(mat));
      endfunction

      task check_quat(input quat_type got);
         quat_type want;
         comp_type which;
         if (pending_quats.size() == 0) begin
            report_mismatch("unexpected quaternion word");
            return;
         end
         want = pending_quats.pop_front();
         for (int c = 0; c < NUM_COMP; c++) begin
            which = comp_type'(c);
            if (got.comp[c] !== want.comp[c])
               report_mismatch($sformatf("%s got %0d want %0d",
                  which.name(), got.comp[c], want.comp[c]));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   elem_type req_m[3][3];
   logic rsp_valid;
   elem_type rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_scoreboard board = new();
   int send_idle_pct = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   initial begin
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            req_m[r][c] = '0;
   end

   rotation_matrix_to_quaternion dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_m00(req_m[0][0]), .req_m01(req_m[0][1]), .req_m02(req_m[0][2]),
      .req_m10(req_m[1][0]), .req_m11(req_m[1][1]), .req_m12(req_m[1][2]),
      .req_m20(req_m[2][0]), .req_m21(req_m[2][1]), .req_m22(req_m[2][2]),
      .rsp_valid(rsp_valid),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z)
   );

   // Result monitor: strobe cannot be held off, so sample every edge.
   always @(posedge clock) begin
      quat_type got;
      if (!reset && rsp_valid) begin
         got.comp[COMP_W] = rsp_quat_w;
         got.comp[COMP_X] = rsp_quat_x;
         got.comp[COMP_Y] = rsp_quat_y;
         got.comp[COMP_Z] = rsp_quat_z;
         board.check_quat(got);
      end
   end

   // Watchdog: cycles without any accepted word or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[rotation_matrix_to_quaternion] ERROR");
            $finish;
         end
      end
   end

   // Drive one matrix word; start stays high across back-to-back words.
   task automatic send_matrix(input matrix_type mat);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            req_m[r][c] <= mat.m[r][c];
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_matrix(mat);
   endtask

   task automatic send_idle_word();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic elem_type rand_elem();
      return elem_type'($urandom_range(65535, 0));
   endfunction

   // Near-rotation matrix: random axis-style mix around one of the orthogonal bases
   function automatic matrix_type rand_rotation();
      matrix_type mat;
      real ang;
      real cs;
      real sn;
      int ax;
      int b;
      int d;
      real rm[3][3];
      ang = ($urandom_range(62831, 0)) / 10000.0;
      cs = $cos(ang);
      sn = $sin(ang);
      ax = $urandom_range(2, 0);
      b = (ax + 1) % 3;
      d = (b + 1) % 3;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            rm[r][c] = 0.0;
      rm[ax][ax] = 1.0;
      rm[b][b] = cs;  rm[b][d] = -sn;
      rm[d][b] = sn;  rm[d][d] = cs;
      // a second flip makes the non-trace paths likelier
      if ($urandom_range(1, 0)) begin
         for (int c = 0; c < 3; c++) begin
            rm[b][c] = -rm[b][c];
            rm[d][c] = -rm[d][c];
         end
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            mat.m[r][c] = elem_type'($rtoi(rm[r][c] * 16384.0)
               + $signed($urandom_range(8, 0)) - 4);
      return mat;
   endfunction

   function automatic matrix_type rand_matrix();
      matrix_type mat;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            mat.m[r][c] = rand_elem();
      return mat;
   endfunction

   function automatic matrix_type fill_matrix(input elem_type diag, input elem_type off);
      matrix_type mat;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            mat.m[r][c] = (r == c) ? diag : off;
      return mat;
   endfunction

   initial begin
      matrix_type mat;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, extremes, every pivot, ties, negative root, saturation.
      send_matrix(fill_matrix(16'sd16384, 16'sd0));
      send_matrix(fill_matrix(16'sh7fff, 16'sh7fff));
      send_matrix(fill_matrix(16'sh8000, 16'sh8000));
      send_matrix(fill_matrix(16'sh8000, 16'sh7fff));
      send_matrix(fill_matrix(16'sh7fff, 16'sh8000));
      send_matrix(fill_matrix(16'sd0, 16'sd0));            // ties, zero trace
      send_matrix(fill_matrix(-16'sd16384, 16'sd0));       // tie on all pivots
      mat = fill_matrix(-16'sd16384, 16'sd0);              // pivot x
      mat.m[0][0] = 16'sd16384;
      send_matrix(mat);
      mat = fill_matrix(-16'sd16384, 16'sd0);              // pivot y
      mat.m[1][1] = 16'sd16384;
      send_matrix(mat);
      mat = fill_matrix(-16'sd16384, 16'sd0);              // pivot z
      mat.m[2][2] = 16'sd16384;
      send_matrix(mat);
      mat = fill_matrix(16'sd0, 16'sd0);                   // tie between y and z
      mat.m[0][0] = -16'sd20000;
      mat.m[1][1] = 16'sd100;
      mat.m[2][2] = 16'sd100;
      send_matrix(mat);
      mat = fill_matrix(-16'sd20000, 16'sd0);              // negative diagonal, pivot x
      mat.m[0][0] = -16'sd10000;
      send_matrix(mat);
      mat = fill_matrix(16'sd1, 16'sh7fff);                // large off-diagonal differences
      mat.m[1][2] = 16'sh8000;
      mat.m[0][1] = 16'sh8000;
      send_matrix(mat);
      mat = fill_matrix(-16'sd1, 16'sh7fff);
      mat.m[2][1] = 16'sh8000;
      send_matrix(mat);
      for (int n = 0; n < 6; n++) send_matrix(rand_rotation());

      // Random phases: no idling, sender mostly idle, sender lightly idle, no idling.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; end
            1: begin send_idle_pct = 72; end
            2: begin send_idle_pct = 19; end
            default: begin send_idle_pct = 0; end
         endcase
         for (int n = 0; n < 120; n++) begin
            if ($urandom_range(3, 0) == 0) send_matrix(rand_matrix());
            else send_matrix(rand_rotation());
         end
      end
      send_idle_word();

      while (board.pending_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0 && board.pending_quats.size() == 0) begin
         $display("[rotation_matrix_to_quaternion] OK");
      end else begin
         $display("[rotation_matrix_to_quaternion] ERROR");
      end
      $finish;
   end

endmodule
